### hw/rtl/ilha_pkg.sv
// Package for the implicit-list heap allocator: widths, codes and state types.
package ilha_pkg;
  localparam int unsigned HeapBytes = 65536;
  localparam int unsigned WordBytes = 4;
  localparam int unsigned HeapWords = HeapBytes / WordBytes;
  localparam int unsigned AddrW = $clog2(HeapWords);

  localparam logic [1:0] ModeInit  = 2'd0;
  localparam logic [1:0] ModeAlloc = 2'd1;
  localparam logic [1:0] ModeFree  = 2'd2;
  localparam logic [1:0] ModeNop   = 2'd3;

  localparam logic [1:0] StDone = 2'd0;
  localparam logic [1:0] StZero = 2'd1;
  localparam logic [1:0] StOos  = 2'd2;

  localparam logic RegChunk = 1'b0;
  localparam logic RegLimit = 1'b1;

  typedef enum logic [4:0] {
    S_IDLE, S_INIT, S_GROW0, S_GROW1, S_GROW2, S_MRG_RD, S_MRG_W1, S_MRG_W2,
    S_MRG_PV, S_MRG_NX, S_MRG_CALC, S_FIT_RD, S_FIT_CHK, S_PUT, S_PUT2,
    S_PUT3, S_FREE_RD, S_FREE_W, S_DONE, S_MRG_RD2, S_MRG_RD3
  } state_e;
endpackage

### hw/rtl/ilha_ram.sv
// Single-port word memory with registered read data for the heap.
module ilha_ram import ilha_pkg::*; (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [31:0]      wdata_i,
  output logic [31:0]      rdata_o
);
  logic [31:0] mem [HeapWords];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end
endmodule

### hw/rtl/implicit_list_heap_allocator.sv
// Top level of the implicit-list first-fit heap allocator.
// Usage: raise start with mode_i, request_bytes_i and block_addr_i while
// busy is low; the word is taken at that edge and busy rises. When the
// operation ends, done_o is high for exactly one cycle with result_addr_o and
// status_o; the receiver cannot hold the result off. busy falls in the cycle
// after done_o, and the next word can be taken in that cycle at the earliest.
// Configuration writes (cfg_we_i, cfg_idx_i, cfg_wdata_i) are taken at any
// edge and must only be made while the block is idle.
// Every heap word access uses the single memory port, and read data is
// registered. Init writes the prologue and epilogue words and then grows the
// heap by one chunk, which is refused when it does not fit; free clears the
// allocated bit and then merges the block with free neighbours; allocate
// reads each block header visited by the first-fit walk, grows the heap
// first when no block fits, and then places the block, or ends when growth
// is refused. Words rejected at once (zero size, heap not initialised, limit
// too small) go straight to done_o. One operation is in flight at a time.
// Reset clears the break address so the heap reads as empty; memory contents
// are undefined until an init operation writes them.
module implicit_list_heap_allocator import ilha_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode_i,
  input  logic [15:0] request_bytes_i,
  input  logic [15:0] block_addr_i,
  output logic        done_o,
  output logic [15:0] result_addr_o,
  output logic [1:0]  status_o,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [16:0] cfg_wdata_i
);
  state_e st_q, st_d;
  logic [16:0] chunk_q, limit_q;
  logic [31:0] brk_q, brk_d;
  logic [31:0] bp_q, bp_d, asz_q, asz_d, sz_q, sz_d, nsz_q, nsz_d;
  logic [31:0] pf_q, pf_d, nh_q, nh_d, tmp_q, tmp_d;
  logic [1:0]  mode_q, mode_d, stat_q, stat_d;
  logic [2:0]  sub_q, sub_d;
  logic        fromalloc_q, fromalloc_d;
  logic [15:0] res_q, res_d;
  logic        we;
  logic [31:0] wa, wdat, rdata;
  logic [31:0] lim, chunk, grow_sz, g, prev;

  ilha_ram u_ram (.clk_i, .we_i(we), .addr_i(wa[AddrW+1:2]), .wdata_i(wdat),
                  .rdata_o(rdata));

  assign lim = (limit_q < 17'(HeapBytes)) ? {15'd0, limit_q} : HeapBytes;
  assign chunk = (chunk_q < 17'd8) ? 32'd8 : {15'd0, chunk_q};
  assign g = (asz_q > chunk) ? asz_q : chunk;
  assign prev = bp_q - (pf_q & ~32'h7);
  always_comb begin
    logic [31:0] w;
    w = ((mode_q == ModeInit) ? chunk : g) >> 2;
    grow_sz = (w[0] ? w + 32'd1 : w) << 2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; brk_q <= '0; chunk_q <= 17'd4096; limit_q <= 17'd65536;
    end else begin
      st_q <= st_d; brk_q <= brk_d;
      if (cfg_we_i && cfg_idx_i == RegChunk) chunk_q <= cfg_wdata_i;
      if (cfg_we_i && cfg_idx_i == RegLimit) limit_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    bp_q <= bp_d; asz_q <= asz_d; sz_q <= sz_d; nsz_q <= nsz_d; pf_q <= pf_d;
    nh_q <= nh_d; tmp_q <= tmp_d; mode_q <= mode_d; stat_q <= stat_d;
    sub_q <= sub_d; fromalloc_q <= fromalloc_d; res_q <= res_d;
  end

  assign busy = (st_q != S_IDLE);
  assign done_o = (st_q == S_DONE);
  assign result_addr_o = res_q;
  assign status_o = stat_q;

  always_comb begin
    st_d = st_q; brk_d = brk_q; bp_d = bp_q; asz_d = asz_q; sz_d = sz_q;
    nsz_d = nsz_q; pf_d = pf_q; nh_d = nh_q; tmp_d = tmp_q; mode_d = mode_q;
    stat_d = stat_q; sub_d = sub_q; fromalloc_d = fromalloc_q; res_d = res_q;
    we = 1'b0; wa = '0; wdat = '0;
    unique case (st_q)
      S_IDLE: if (start) begin
        mode_d = mode_i; stat_d = StDone; res_d = '0; sub_d = '0;
        fromalloc_d = 1'b0;
        bp_d = {16'd0, block_addr_i};
        asz_d = (request_bytes_i <= 16'd8) ? 32'd16
              : ({16'd0, request_bytes_i} + 32'd15) & ~32'h7;
        unique case (mode_i)
          ModeInit: begin
            brk_d = '0;
            if (lim < 32'd16) begin stat_d = StOos; st_d = S_DONE; end
            else st_d = S_INIT;
          end
          ModeAlloc: begin
            if (request_bytes_i == 16'd0) begin stat_d = StZero; st_d = S_DONE; end
            else if (brk_q == '0) begin stat_d = StOos; st_d = S_DONE; end
            else begin bp_d = 32'd8; st_d = S_FIT_RD; end
          end
          ModeFree: st_d = (brk_q != '0) ? S_FREE_RD : S_DONE;
          default: st_d = S_DONE;
        endcase
      end
      S_INIT: begin
        we = 1'b1; wa = {27'd0, sub_q, 2'b00};
        unique case (sub_q[1:0])
          2'd0: wdat = '0;
          2'd1, 2'd2: wdat = 32'h9;
          default: wdat = 32'h1;
        endcase
        sub_d = sub_q + 3'd1;
        if (sub_q == 3'd3) begin brk_d = 32'd16; st_d = S_GROW0; end
      end
      S_GROW0: begin
        // The new block takes the old epilogue word as its header.
        if ({1'b0, brk_q} + {1'b0, grow_sz} > {1'b0, lim}) begin
          stat_d = StOos; st_d = S_DONE;
        end else begin
          sz_d = grow_sz; bp_d = brk_q;
          we = 1'b1; wa = brk_q - 32'd4; wdat = grow_sz; st_d = S_GROW1;
        end
      end
      S_GROW1: begin
        we = 1'b1; wa = bp_q + sz_q - 32'd8; wdat = sz_q; st_d = S_GROW2;
      end
      S_GROW2: begin
        we = 1'b1; wa = bp_q + sz_q - 32'd4; wdat = 32'h1;
        brk_d = bp_q + sz_q; st_d = S_MRG_RD;
      end
      S_MRG_RD: begin wa = bp_q - 32'd4; st_d = S_MRG_RD2; end
      S_MRG_RD2: begin
        sz_d = rdata & ~32'h7; wa = bp_q - 32'd8; st_d = S_MRG_RD3;
      end
      S_MRG_RD3: begin
        pf_d = rdata; wa = bp_q + sz_q - 32'd4; st_d = S_MRG_PV;
      end
      S_MRG_PV: begin
        nh_d = rdata; nsz_d = rdata & ~32'h7;
        wa = prev - 32'd4; st_d = S_MRG_NX;
      end
      S_MRG_NX: begin
        tmp_d = rdata & ~32'h7;
        wa = bp_q + sz_q + nsz_q - 32'd8; st_d = S_MRG_CALC;
      end
      S_MRG_CALC: begin
        priority if (pf_q[0] && nh_q[0]) begin
          st_d = fromalloc_q ? S_PUT : S_DONE;
        end else if (pf_q[0]) begin
          sz_d = sz_q + nsz_q; tmp_d = bp_q; st_d = S_MRG_W1;
        end else if (nh_q[0]) begin
          tmp_d = sz_q; sz_d = sz_q + tmp_q; st_d = S_MRG_W1;
        end else begin
          sz_d = sz_q + tmp_q + (rdata & ~32'h7); st_d = S_MRG_W1;
          tmp_d = bp_q + sz_q + nsz_q;
        end
      end
      S_MRG_W1: begin
        we = 1'b1; wdat = sz_q; st_d = S_MRG_W2;
        priority if (pf_q[0]) wa = bp_q - 32'd4;
        else if (nh_q[0]) wa = bp_q + tmp_q - 32'd8;
        else wa = prev - 32'd4;
      end
      S_MRG_W2: begin
        we = 1'b1; wdat = sz_q;
        priority if (pf_q[0]) wa = bp_q + sz_q - 32'd8;
        else if (nh_q[0]) wa = prev - 32'd4;
        else wa = tmp_q - 32'd8;
        if (!pf_q[0]) bp_d = prev;
        st_d = fromalloc_q ? S_PUT : S_DONE;
      end
      S_FIT_RD: begin
        if (bp_q >= brk_q) st_d = S_GROW0;
        else begin wa = bp_q - 32'd4; st_d = S_FIT_CHK; end
      end
      S_FIT_CHK: begin
        wa = bp_q - 32'd4;
        if ((rdata & ~32'h7) == '0) st_d = S_GROW0;
        else if (!rdata[0] && asz_q <= (rdata & ~32'h7)) begin
          fromalloc_d = 1'b1; st_d = S_PUT;
        end else if ({1'b0, bp_q} + {1'b0, rdata & ~32'h7} >= {1'b0, brk_q})
          st_d = S_GROW0;
        else begin bp_d = bp_q + (rdata & ~32'h7); st_d = S_FIT_RD; end
        if (st_d == S_GROW0) fromalloc_d = 1'b1;
      end
      S_PUT: begin wa = bp_q - 32'd4; st_d = S_PUT2; sub_d = '0; end
      S_PUT2: begin
        sz_d = rdata & ~32'h7; st_d = S_PUT3; res_d = bp_q[15:0];
      end
      S_PUT3: begin
        we = 1'b1; sub_d = sub_q + 3'd1;
        if (sz_q >= asz_q && sz_q - asz_q >= 32'd16) begin
          unique case (sub_q[1:0])
            2'd0: begin wa = bp_q - 32'd4; wdat = asz_q | 32'h1; end
            2'd1: begin wa = bp_q + asz_q - 32'd8; wdat = asz_q | 32'h1; end
            2'd2: begin wa = bp_q + asz_q - 32'd4; wdat = sz_q - asz_q; end
            default: begin wa = bp_q + sz_q - 32'd8; wdat = sz_q - asz_q; end
          endcase
          if (sub_q == 3'd3) st_d = S_DONE;
        end else begin
          wdat = sz_q | 32'h1;
          wa = sub_q[0] ? bp_q + sz_q - 32'd8 : bp_q - 32'd4;
          if (sub_q == 3'd1) st_d = S_DONE;
        end
      end
      S_FREE_RD: begin wa = bp_q - 32'd4; st_d = S_FREE_W; sub_d = '0; end
      S_FREE_W: begin
        we = 1'b1; sub_d = sub_q + 3'd1;
        if (sub_q == 3'd0) begin
          sz_d = rdata & ~32'h7; wa = bp_q - 32'd4; wdat = rdata & ~32'h7;
        end else begin
          wa = bp_q + sz_q - 32'd8; wdat = sz_q; st_d = S_MRG_RD;
        end
      end
      S_DONE: begin
        // A failed growth during allocate reports no block.
        if (stat_q == StOos) res_d = '0;
        st_d = S_IDLE;
      end
      default: st_d = S_IDLE;
    endcase
  end
endmodule

### test/implicit_list_heap_allocator_test.sv
// Self-checking testbench for the implicit-list first-fit heap allocator.
`timescale 1ns / 1ps

module implicit_list_heap_allocator_test;
  import ilha_pkg::*;

  localparam int unsigned IdleLimit = 50000;

  typedef struct packed {
    logic [15:0] addr;
    logic [1:0]  status;
  } reply_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  mode_i = ModeInit;
  logic [15:0] request_bytes_i = '0;
  logic [15:0] block_addr_i = '0;
  logic        done_o;
  logic [15:0] result_addr_o;
  logic [1:0]  status_o;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = RegChunk;
  logic [16:0] cfg_wdata_i = '0;

  implicit_list_heap_allocator uut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Predictor state: heap image, break and the two registers.
  logic [31:0] heap_img [HeapWords];
  int unsigned brk_p;
  int unsigned chunk_p;
  int unsigned limit_p;

  reply_t      reply_q[$];
  int unsigned live_blocks[$];
  int unsigned err_cnt, item_cnt, reply_cnt, granted_cnt, oos_cnt, free_cnt;

  function automatic int unsigned hrd(int unsigned a);
    return heap_img[(a / WordBytes) % HeapWords];
  endfunction

  function automatic void hwr(int unsigned a, int unsigned v);
    heap_img[(a / WordBytes) % HeapWords] = v;
  endfunction

  function automatic int unsigned eff_limit();
    return (limit_p < HeapBytes) ? limit_p : HeapBytes;
  endfunction

  function automatic int unsigned eff_chunk();
    return (chunk_p < 8) ? 8 : chunk_p;
  endfunction

  function automatic int unsigned coalesce(int unsigned bp);
    int unsigned size, pf, nxt, nh, nsize, prv, oldsize;
    size = hrd(bp - 4) & ~32'h7;
    pf = hrd(bp - 8);
    nxt = bp + size;
    nh = hrd(nxt - 4);
    nsize = nh & ~32'h7;
    prv = bp - (pf & ~32'h7);
    oldsize = size;
    if (pf[0] && nh[0]) return bp;
    if (pf[0]) begin
      size += nsize;
      hwr(bp - 4, size);
      hwr(bp + size - 8, size);
      return bp;
    end
    if (nh[0]) begin
      size += hrd(prv - 4) & ~32'h7;
      hwr(bp + oldsize - 8, size);
      hwr(prv - 4, size);
      return prv;
    end
    size += (hrd(prv - 4) & ~32'h7) + (hrd(nxt + nsize - 8) & ~32'h7);
    hwr(prv - 4, size);
    hwr(nxt + nsize - 8, size);
    return prv;
  endfunction

  function automatic int unsigned grow_heap(int unsigned bytes);
    int unsigned words, size, bp;
    words = bytes / WordBytes;
    size = (words[0] ? words + 1 : words) * WordBytes;
    bp = brk_p;
    if (longint'(bp) + longint'(size) > longint'(eff_limit())) return 0;
    hwr(bp - 4, size);
    hwr(bp + size - 8, size);
    hwr(bp + size - 4, 1);
    brk_p = bp + size;
    return coalesce(bp);
  endfunction

  function automatic int unsigned scan_first_fit(int unsigned asize);
    int unsigned bp, h, sz;
    bp = 2 * WordBytes;
    while (bp < brk_p) begin
      h = hrd(bp - 4);
      sz = h & ~32'h7;
      if (sz == 0) break;
      if (!h[0] && asize <= sz) return bp;
      if (longint'(bp) + longint'(sz) >= longint'(brk_p)) break;
      bp += sz;
    end
    return 0;
  endfunction

  function automatic void place_block(int unsigned bp, int unsigned asize);
    int unsigned csize;
    csize = hrd(bp - 4) & ~32'h7;
    if (csize >= asize && csize - asize >= 16) begin
      hwr(bp - 4, asize | 1);
      hwr(bp + asize - 8, asize | 1);
      bp += asize;
      hwr(bp - 4, csize - asize);
      hwr(bp + csize - asize - 8, csize - asize);
    end else begin
      hwr(bp - 4, csize | 1);
      hwr(bp + csize - 8, csize | 1);
    end
  endfunction

  function automatic reply_t heap_predict(logic [1:0] m, logic [15:0] rq, logic [15:0] ba);
    reply_t r;
    int unsigned asize, bp, sz, a;
    r.addr = '0;
    r.status = StDone;
    a = 32'(ba);
    if (m == ModeInit) begin
      brk_p = 0;
      if (eff_limit() < 16) begin
        r.status = StOos;
      end else begin
        hwr(0, 0);
        hwr(4, 9);
        hwr(8, 9);
        hwr(12, 1);
        brk_p = 16;
        if (grow_heap(eff_chunk()) == 0) r.status = StOos;
      end
    end else if (m == ModeAlloc) begin
      if (rq == 0) begin
        r.status = StZero;
      end else if (brk_p == 0) begin
        r.status = StOos;
      end else begin
        asize = (rq <= 8) ? 16 : 8 * ((int'(rq) + 15) / 8);
        bp = scan_first_fit(asize);
        if (bp == 0) bp = grow_heap((asize > eff_chunk()) ? asize : eff_chunk());
        if (bp == 0) begin
          r.status = StOos;
        end else begin
          place_block(bp, asize);
          r.addr = bp[15:0];
        end
      end
    end else if (m == ModeFree) begin
      if (brk_p != 0) begin
        sz = hrd(a - 4) & ~32'h7;
        hwr(a - 4, sz);
        hwr(a + sz - 8, sz);
        void'(coalesce(a));
      end
    end
    return r;
  endfunction

  // Sends one command word and returns the predicted reply.
  task automatic issue_word(input logic [1:0] m, input logic [15:0] rq,
                            input logic [15:0] ba, output reply_t pred);
    repeat ($urandom_range(4) + 1) @(posedge clk_i);
    start <= 1'b1;
    mode_i <= m;
    request_bytes_i <= rq;
    block_addr_i <= ba;
    do @(posedge clk_i); while (busy);
    start <= 1'b0;
    pred = heap_predict(m, rq, ba);
    reply_q.push_back(pred);
    item_cnt++;
    if (m == ModeInit) live_blocks.delete();
    if (m == ModeAlloc && pred.status == StDone) begin
      live_blocks.push_back(32'(pred.addr));
      granted_cnt++;
    end
    if (pred.status == StOos) oos_cnt++;
  endtask

  task automatic do_alloc(input logic [15:0] rq);
    reply_t p;
    issue_word(ModeAlloc, rq, 16'($urandom), p);
  endtask

  task automatic do_init();
    reply_t p;
    issue_word(ModeInit, 16'($urandom), 16'($urandom), p);
  endtask

  // Frees a live block chosen at random, or allocates when none is live; before init any address is ignored.
  task automatic do_free();
    reply_t p;
    int unsigned idx;
    logic [15:0] ba;
    if (brk_p == 0) begin
      ba = 16'($urandom);
    end else if (live_blocks.size() == 0) begin
      do_alloc(16'($urandom_range(1, 64)));
      return;
    end else begin
      idx = $urandom_range(live_blocks.size() - 1);
      ba = live_blocks[idx][15:0];
      live_blocks.delete(idx);
    end
    free_cnt++;
    issue_word(ModeFree, 16'($urandom), ba, p);
  endtask

  task automatic wait_idle();
    while (reply_q.size() != 0 || busy) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [16:0] val);
    wait_idle();
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == RegChunk) chunk_p = 32'(val);
    else limit_p = 32'(val);
  endtask

  task automatic test_before_init();
    reply_t p;
    do_alloc(16'd1);
    do_alloc(16'd0);
    issue_word(ModeFree, 16'hFFFF, 16'hFFFF, p);
    issue_word(ModeFree, 16'h0000, 16'h0000, p);
    issue_word(ModeNop, 16'hFFFF, 16'hFFFF, p);
  endtask

  task automatic test_tiny_limits();
    write_reg(RegLimit, 17'd0);
    do_init();
    do_alloc(16'd1);
    write_reg(RegLimit, 17'd16);
    do_init();
    do_alloc(16'd1);
  endtask

  task automatic test_small_chunk();
    write_reg(RegLimit, 17'h1FFFF);
    write_reg(RegChunk, 17'd0);
    do_init();
    do_alloc(16'd8);
    do_alloc(16'd9);
    do_alloc(16'd1);
    do_free();
    do_free();
  endtask

  task automatic test_huge_requests();
    write_reg(RegChunk, 17'd65536);
    do_init();
    do_alloc(16'hFFFF);
    do_alloc(16'd1);
  endtask

  task automatic test_merge_cases();
    reply_t a0, a1, a2;
    write_reg(RegChunk, 17'd4096);
    write_reg(RegLimit, 17'd65536);
    do_init();
    issue_word(ModeAlloc, 16'd100, 16'd0, a0);
    issue_word(ModeAlloc, 16'd200, 16'd0, a1);
    issue_word(ModeAlloc, 16'd300, 16'd0, a2);
    live_blocks.delete();
    // Middle first, then its neighbours, so no merge, a merge with the next block and a merge on both sides occur.
    issue_word(ModeFree, 16'd0, a1.addr, a1);
    issue_word(ModeFree, 16'd0, a0.addr, a0);
    issue_word(ModeFree, 16'd0, a2.addr, a2);
    do_alloc(16'd0);
    free_cnt += 3;
    wait_idle();
  endtask

  task automatic test_random_phases();
    int unsigned r;
    reply_t p;
    for (int ph = 0; ph < 11; ph++) begin
      case ($urandom_range(3))
        0: write_reg(RegChunk, 17'($urandom_range(7)));
        1: write_reg(RegChunk, 17'd8);
        2: write_reg(RegChunk, 17'd4096);
        default: write_reg(RegChunk, 17'($urandom_range(8, 1024)));
      endcase
      case ($urandom_range(3))
        0: write_reg(RegLimit, 17'd65536);
        1: write_reg(RegLimit, 17'h1FFFF);
        2: write_reg(RegLimit, 17'($urandom_range(32, 8192)));
        default: write_reg(RegLimit, 17'($urandom_range(12, 48)));
      endcase
      do_init();
      for (int i = 0; i < 100; i++) begin
        r = $urandom_range(99);
        if (r < 4) issue_word(ModeNop, 16'($urandom), 16'($urandom), p);
        else if (r < 7) do_alloc(16'd0);
        else if (r < 9) do_init();
        else if (r < 55) begin
          r = $urandom_range(49);
          if (r == 0) do_alloc(16'($urandom));
          else if (r < 6) do_alloc(16'($urandom_range(1, 2000)));
          else do_alloc(16'($urandom_range(1, 64)));
        end else do_free();
      end
    end
  endtask

  // Each result word is compared against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      reply_cnt++;
      if (reply_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("unexpected result addr=%0d status=%0d",
                                    result_addr_o, status_o);
      end else begin
        if (result_addr_o !== reply_q[0].addr || status_o !== reply_q[0].status) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("mismatch: expected addr=%0d status=%0d, got addr=%0d status=%0d",
                     reply_q[0].addr, reply_q[0].status, result_addr_o, status_o);
        end
        void'(reply_q.pop_front());
      end
    end
  end

  int unsigned idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("watchdog expired");
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    brk_p = 0;
    chunk_p = 4096;
    limit_p = 65536;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_before_init();
    test_tiny_limits();
    test_small_chunk();
    test_huge_requests();
    test_merge_cases();
    test_random_phases();
    wait_idle();
    repeat (50) @(posedge clk_i);
    if (reply_q.size() != 0) err_cnt++;
    $display("Ran %0d commands with %0d results checked: %0d blocks granted,", item_cnt,
             reply_cnt, granted_cnt);
    $display("%0d frees and %0d out-of-space replies across varied chunk and limit settings.",
             free_cnt, oos_cnt);
    if (err_cnt == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule
